>>> src/rlbc_pkg.sv
// Shared types and codes for the reference-counted LRU block cache.
`default_nettype none

package rlbc_pkg;

	// Slot index width inside the block; it covers up to 256 slots.
	localparam int IDX_W = 8;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		FUNC_GET     = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_PIN     = 2'd2,
		FUNC_UNPIN   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_NOFREE = 2'd1,
		STATUS_UNDER  = 2'd2,
		STATUS_SAT    = 2'd3
	} status_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  device_id;
		logic [31:0] block_number;
		logic [4:0]  slot_index;
		logic [31:0] now_tick;
	} req_t;

	typedef struct packed {
		logic [4:0] result_slot;
		logic       hit;
		logic       need_fill;
		status_t    status;
	} rsp_t;

	// Search key broadcast to every cell while a word is in flight.
	typedef struct packed {
		logic [7:0]       device;
		logic [31:0]      block;
		logic [IDX_W-1:0] sel_idx;
	} key_t;

	// Partial search result handed from cell to cell.
	typedef struct packed {
		logic             live;
		logic             hit_found;
		logic [IDX_W-1:0] hit_idx;
		logic [7:0]       hit_cnt;
		logic             hit_valid;
		logic             free_found;
		logic [IDX_W-1:0] vic_idx;
		logic [31:0]      vic_time;
		logic [7:0]       sel_cnt;
	} token_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_INC   = 2'd1,
		CMD_DEC   = 2'd2,
		CMD_RETAG = 2'd3
	} cmd_op_t;

	// Slot update broadcast to the cells at the end of a request.
	typedef struct packed {
		logic             en;
		cmd_op_t          op;
		logic [IDX_W-1:0] idx;
		logic             set_valid;
		logic             stamp;
		logic [7:0]       device;
		logic [31:0]      block;
		logic [31:0]      tick;
	} cmd_t;

endpackage

`default_nettype wire

>>> src/rlbc_cell.sv
// One buffer slot: tag, count, release time and valid bit, plus one search stage.
`default_nettype none

module rlbc_cell #(
	parameter int CELL_INDEX = 0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire rlbc_pkg::key_t     key,
	input  wire rlbc_pkg::token_t   tok_in,
	output rlbc_pkg::token_t        tok_out,
	input  wire rlbc_pkg::cmd_t     cmd
);

	localparam int IW = rlbc_pkg::IDX_W;
	localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

	logic [7:0]       dev_q;
	logic [31:0]      blk_q;
	logic [7:0]       cnt_q;
	logic [31:0]      time_q;
	logic             valid_q;
	rlbc_pkg::token_t tok_q;
	rlbc_pkg::token_t tok_nxt;
	logic             match;

	assign match = (dev_q == key.device) && (blk_q == key.block);

	// First match wins; a free slot replaces the victim only on a strictly older time.
	always_comb begin
		tok_nxt = tok_in;
		if (!tok_in.hit_found && match) begin
			tok_nxt.hit_found = 1'b1;
			tok_nxt.hit_idx   = MY_IDX;
			tok_nxt.hit_cnt   = cnt_q;
			tok_nxt.hit_valid = valid_q;
		end
		if ((cnt_q == 8'd0) && (!tok_in.free_found || (time_q < tok_in.vic_time))) begin
			tok_nxt.free_found = 1'b1;
			tok_nxt.vic_idx    = MY_IDX;
			tok_nxt.vic_time   = time_q;
		end
		if (key.sel_idx == MY_IDX) begin
			tok_nxt.sel_cnt = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q   <= '0;
			blk_q   <= '0;
			cnt_q   <= '0;
			time_q  <= '0;
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (cmd.en && (cmd.idx == MY_IDX)) begin
				unique case (cmd.op)
					rlbc_pkg::CMD_INC: begin
						cnt_q <= cnt_q + 8'd1;
					end
					rlbc_pkg::CMD_DEC: begin
						cnt_q <= cnt_q - 8'd1;
						if (cmd.stamp) begin
							time_q <= cmd.tick;
						end
					end
					rlbc_pkg::CMD_RETAG: begin
						dev_q <= cmd.device;
						blk_q <= cmd.block;
						cnt_q <= 8'd1;
					end
					rlbc_pkg::CMD_NONE: begin
					end
					default: begin
					end
				endcase
				if (cmd.set_valid) begin
					valid_q <= 1'b1;
				end
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

>>> src/refcounted_lru_block_cache.sv
// Top level of the reference-counted LRU block cache: sequencer, chain of slot cells, response register.
//
// Usage:
//   req channel (req, req_valid, req_stall) takes one word per request: get, release,
//   pin or unpin. rsp channel (rsp, rsp_valid, rsp_stall) returns exactly one word per
//   request, in request order.
//   A request is handled one at a time. After acceptance a search token walks the row
//   of SLOT_COUNT cells, one cell per cycle, collecting the lowest matching tag, the
//   oldest free slot and the count of the addressed slot. The token at the end of the
//   chain is registered; once the response register is free, the slot update is applied
//   and the response register is loaded.
//   req_stall is high while a request is in flight. A finished response waits in its
//   register while rsp_stall is high; the next request may be accepted meanwhile, and
//   its search completes but its update and response hold until the register frees.
//   Reset clears every slot to tag device 0 / block 0, count 0, time 0, not valid,
//   and leaves both channels idle.
`default_nettype none

module refcounted_lru_block_cache #(
	parameter int SLOT_COUNT = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire rlbc_pkg::req_t  req,
	input  wire                  req_valid,
	output logic                 req_stall,
	output rlbc_pkg::rsp_t       rsp,
	output logic                 rsp_valid,
	input  wire                  rsp_stall
);

	localparam int IW = rlbc_pkg::IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_DONE   = 3'b100
	} state_t;

	state_t           state_q;
	rlbc_pkg::req_t   req_q;
	logic             start_q;
	rlbc_pkg::token_t end_q;
	rlbc_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	rlbc_pkg::token_t tok [SLOT_COUNT+1];
	rlbc_pkg::token_t tok_head;
	rlbc_pkg::key_t   key;
	rlbc_pkg::cmd_t   cmd;
	rlbc_pkg::rsp_t   rsp_nxt;

	logic             accept;
	logic             out_free;
	logic             sel_ok;
	logic             finish;

	assign accept    = (state_q == ST_IDLE) && req_valid;
	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign finish    = (state_q == ST_DONE) && out_free;
	assign sel_ok    = 9'(req_q.slot_index) < 9'(SLOT_COUNT);

	// Broadcast the held request as the search key.
	assign key.device  = req_q.device_id;
	assign key.block   = req_q.block_number;
	assign key.sel_idx = IW'(req_q.slot_index);

	// Inject a fresh token at the head of the chain for one cycle after acceptance.
	always_comb begin
		tok_head      = '0;
		tok_head.live = start_q;
	end

	assign tok[0] = tok_head;

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		rlbc_cell #(
			.CELL_INDEX (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (key),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.cmd     (cmd)
		);
	end

	// Decide the slot update and the response from the finished search.
	always_comb begin
		cmd.en        = finish;
		cmd.op        = rlbc_pkg::CMD_NONE;
		cmd.idx       = key.sel_idx;
		cmd.set_valid = 1'b0;
		cmd.stamp     = 1'b0;
		cmd.device    = req_q.device_id;
		cmd.block     = req_q.block_number;
		cmd.tick      = req_q.now_tick;

		rsp_nxt.result_slot = req_q.slot_index;
		rsp_nxt.hit         = 1'b0;
		rsp_nxt.need_fill   = 1'b0;
		rsp_nxt.status      = rlbc_pkg::STATUS_OK;

		if (req_q.func == rlbc_pkg::FUNC_GET) begin
			if (end_q.hit_found) begin
				// Hit: bump the count unless saturated, mark contents valid either way.
				cmd.idx             = end_q.hit_idx;
				cmd.set_valid       = 1'b1;
				rsp_nxt.result_slot = end_q.hit_idx[4:0];
				rsp_nxt.hit         = 1'b1;
				rsp_nxt.need_fill   = !end_q.hit_valid;
				if (end_q.hit_cnt == rlbc_pkg::COUNT_MAX) begin
					rsp_nxt.status = rlbc_pkg::STATUS_SAT;
				end else begin
					cmd.op = rlbc_pkg::CMD_INC;
				end
			end else if (end_q.free_found) begin
				// Miss: retag the oldest free slot.
				cmd.op              = rlbc_pkg::CMD_RETAG;
				cmd.idx             = end_q.vic_idx;
				cmd.set_valid       = 1'b1;
				rsp_nxt.result_slot = end_q.vic_idx[4:0];
				rsp_nxt.need_fill   = 1'b1;
			end else begin
				rsp_nxt.result_slot = 5'd0;
				rsp_nxt.status      = rlbc_pkg::STATUS_NOFREE;
			end
		end else if (sel_ok) begin
			if (req_q.func == rlbc_pkg::FUNC_PIN) begin
				if (end_q.sel_cnt == rlbc_pkg::COUNT_MAX) begin
					rsp_nxt.status = rlbc_pkg::STATUS_SAT;
				end else begin
					cmd.op = rlbc_pkg::CMD_INC;
				end
			end else begin
				if (end_q.sel_cnt == 8'd0) begin
					rsp_nxt.status = rlbc_pkg::STATUS_UNDER;
				end else begin
					cmd.op    = rlbc_pkg::CMD_DEC;
					// Stamp the tick only on a release that drops the last reference.
					cmd.stamp = (req_q.func == rlbc_pkg::FUNC_RELEASE) &&
						(end_q.sel_cnt == 8'd1);
				end
			end
		end
	end

	// Sequencer: idle, walk the chain, then update and respond.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (tok[SLOT_COUNT].live) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the request and the finished token.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if ((state_q == ST_SEARCH) && tok[SLOT_COUNT].live) begin
			end_q <= tok[SLOT_COUNT];
		end
	end

	// Response register: load on finish, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

>>> src/rlbc_checker.sv
// Port-level checks for the reference-counted LRU block cache, bound to the top level.
`default_nettype none

module rlbc_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire rlbc_pkg::req_t req,
	input wire                 req_valid,
	input wire                 req_stall,
	input wire rlbc_pkg::rsp_t rsp,
	input wire                 rsp_valid,
	input wire                 rsp_stall
);

	// A stalled response word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response word changed");

	// One request in flight: an accepted request stalls the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	// A hit never reports a missing slot or an underflow.
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |->
			(rsp.status == rlbc_pkg::STATUS_OK) || (rsp.status == rlbc_pkg::STATUS_SAT))
		else $error("hit with bad status");

	// No free slot returns slot zero with no hit and no fill.
	a_nofree_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == rlbc_pkg::STATUS_NOFREE) |->
			(rsp.result_slot == 5'd0) && !rsp.hit && !rsp.need_fill)
		else $error("no-free response malformed");

	// Unused request fields are still ports of the checker.
	logic unused_req;
	assign unused_req = ^req;

endmodule

bind refcounted_lru_block_cache rlbc_checker u_rlbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req       (req),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp       (rsp),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall)
);

`default_nettype wire
